// ----- rtl/c2g_pkg.sv -----
// c2g_pkg: shared types and constants for the character to glyph segment map
// holds transaction payload structs, the table entry layout and the scan states
// no dependencies
`default_nettype none

package c2g_pkg;

    localparam int CODE_W = 16;
    localparam int SLOT_W = 6;
    localparam int HIT_W  = 6;
    localparam int CFG_W  = 7;

    typedef enum logic
    {
        FUNC_WRITE  = 1'b0,
        FUNC_LOOKUP = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t                     func;
        logic [SLOT_W-1:0]         seg_index;
        logic [CODE_W-1:0]         seg_start;
        logic [CODE_W-1:0]         seg_end;
        logic signed [CODE_W-1:0]  seg_delta;
        logic [CODE_W-1:0]         char_code;
    } req_item_t;

    typedef struct packed
    {
        logic [CODE_W-1:0] glyph_id;
        logic              found;
        logic [HIT_W-1:0]  hit_segment;
    } rsp_item_t;

    // one table slot, 48 bits
    typedef struct packed
    {
        logic [CODE_W-1:0]         seg_start;
        logic [CODE_W-1:0]         seg_end;
        logic signed [CODE_W-1:0]  seg_delta;
    } seg_entry_t;

    typedef struct packed
    {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } scan_state_t;

endpackage : c2g_pkg

`default_nettype wire

// ----- rtl/c2g_seg_mem.sv -----
// c2g_seg_mem: segment table storage, one write port and one registered read port
// depends on c2g_pkg for the entry layout
`default_nettype none

module c2g_seg_mem
    import c2g_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
)
(
    input  wire logic                                               clk,
    input  wire mem_ctrl_t                                          mem_ctl,
    input  wire logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] waddr,
    input  wire seg_entry_t                                         wdata,
    input  wire logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] raddr,
    output      seg_entry_t                                         rdata
);

    seg_entry_t seg_table [MAX_SEGMENTS];
    seg_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            seg_table[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rdata_reg <= seg_table[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : c2g_seg_mem

`default_nettype wire

// ----- rtl/c2g_scan_ctrl.sv -----
// c2g_scan_ctrl: transaction intake, in-order table scan and result register
// depends on c2g_pkg; drives the ports of c2g_seg_mem
`default_nettype none

module c2g_scan_ctrl
    import c2g_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
)
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic [$clog2(MAX_SEGMENTS + 1)-1:0]       scan_limit,
    input  wire logic                                      req_valid,
    output      logic                                      req_ready,
    input  wire req_item_t                                 req,
    output      logic                                      rsp_valid,
    input  wire logic                                      rsp_ready,
    output      rsp_item_t                                 rsp,
    output      mem_ctrl_t                                 mem_ctl,
    output      logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] mem_waddr,
    output      seg_entry_t                                mem_wdata,
    output      logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] mem_raddr,
    input  wire seg_entry_t                                mem_rdata
);

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int LIM_W = $clog2(MAX_SEGMENTS + 1);

    scan_state_t       state_reg, state_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [LIM_W-1:0]  issue_idx_reg, issue_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    rsp_item_t         res_reg, res_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_item_t         rsp_reg, rsp_next;

    logic req_fire;
    logic wr_in_range;
    logic more_slots;
    logic scan_hit;
    logic scan_miss;
    logic rsp_free;
    logic issue;

    assign req_ready   = (state_reg == ST_IDLE);
    assign req_fire    = req_valid && req_ready;
    assign wr_in_range = (32'(req.seg_index) < 32'(MAX_SEGMENTS));
    assign more_slots  = (issue_idx_reg < scan_limit);

    // the returning entry ends the scan once its end code reaches the character
    assign scan_hit  = (state_reg == ST_SCAN) && rd_vld_reg && (mem_rdata.seg_end >= code_reg);
    assign scan_miss = (state_reg == ST_SCAN) && !scan_hit && !more_slots;
    assign issue     = (state_reg == ST_SCAN) && !scan_hit && more_slots;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    assign mem_ctl.wr_en = req_fire && (req.func == FUNC_WRITE) && wr_in_range;
    assign mem_ctl.rd_en = issue;
    assign mem_waddr     = IDX_W'(req.seg_index);
    assign mem_wdata     = '{seg_start: req.seg_start, seg_end: req.seg_end,
                             seg_delta: req.seg_delta};
    assign mem_raddr     = issue_idx_reg[IDX_W-1:0];

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.func == FUNC_LOOKUP))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit || scan_miss)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        code_next      = code_reg;
        issue_idx_next = issue_idx_reg;
        rd_vld_next    = issue;
        rd_idx_next    = rd_idx_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        if (req_fire)
        begin
            code_next      = req.char_code;
            issue_idx_next = '0;
        end

        if (issue)
        begin
            issue_idx_next = issue_idx_reg + LIM_W'(1);
            rd_idx_next    = issue_idx_reg[IDX_W-1:0];
        end

        if (scan_hit)
        begin
            if (mem_rdata.seg_start <= code_reg)
            begin
                res_next.glyph_id    = code_reg + $unsigned(mem_rdata.seg_delta);
                res_next.found       = 1'b1;
                res_next.hit_segment = HIT_W'(rd_idx_reg);
            end
            else
            begin
                res_next = '0;
            end
        end
        else if (scan_miss)
        begin
            res_next = '0;
        end

        if ((state_reg == ST_DONE) && rsp_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        issue_idx_reg <= issue_idx_next;
        rd_idx_reg    <= rd_idx_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

endmodule : c2g_scan_ctrl

`default_nettype wire

// ----- rtl/char_to_glyph_segment_map.sv -----
// char_to_glyph_segment_map: top level, segment count register and block assembly
// depends on c2g_pkg, c2g_seg_mem and c2g_scan_ctrl
//
// Maps 16-bit character codes to glyph ids through a table of up to MAX_SEGMENTS
// segments held in a single-port-read synchronous memory. A write transaction
// (func = write) stores start, end and delta at seg_index and returns
// nothing; slots at or above MAX_SEGMENTS are dropped. A lookup
// transaction walks slots 0, 1, 2, ... below the segment count (saturated to
// MAX_SEGMENTS) and stops at the first slot whose end code is at least the
// character; if that slot's start is also at most the character, found is set
// and glyph_id is code plus delta modulo 65536, otherwise found, glyph_id and
// hit_segment are zero. The scan reads one slot per cycle through the memory
// read port; a finished lookup holds the block while the previous result
// still waits in the output register. The table has no reset: a lookup
// that reaches a never-written slot returns undefined fields. The result sits
// in an output register, so a new transaction is taken while a result still
// waits. segment_count may only be changed while the block is idle.
`default_nettype none

module char_to_glyph_segment_map
    import c2g_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             req_valid,
    output      logic             req_ready,
    input  wire req_item_t        req,
    output      logic             rsp_valid,
    input  wire logic             rsp_ready,
    output      rsp_item_t        rsp
);

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int LIM_W = $clog2(MAX_SEGMENTS + 1);
    localparam int CMP_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;

    // segment count register, reset to an empty table
    logic [CFG_W-1:0] segment_count_reg, segment_count_next;
    logic [LIM_W-1:0] scan_limit;

    // memory port signals between the scanner and the table
    mem_ctrl_t        mem_ctl;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    seg_entry_t       mem_wdata;
    seg_entry_t       mem_rdata;

    assign segment_count_next = cfg_we ? cfg_wdata : segment_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_count_reg <= '0;
        end
        else
        begin
            segment_count_reg <= segment_count_next;
        end
    end

    // counts beyond the table depth search the whole table
    assign scan_limit = (CMP_W'(segment_count_reg) > CMP_W'(MAX_SEGMENTS)) ?
                        LIM_W'(MAX_SEGMENTS) : LIM_W'(segment_count_reg);

    c2g_scan_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_scan_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_limit (scan_limit),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .mem_ctl    (mem_ctl),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    c2g_seg_mem #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_seg_mem (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr   (mem_raddr),
        .rdata   (mem_rdata)
    );

    // table writes only happen at intake, reads only during a scan
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("segment table written and read in the same cycle");

    // the scan never reads past the searched range
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.rd_en |-> (LIM_W'(mem_raddr) < scan_limit))
        else $error("segment table read beyond the segment count");

    // a miss carries zero glyph and zero slot
    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found) |-> ((rsp.glyph_id == '0) && (rsp.hit_segment == '0)))
        else $error("miss transaction with nonzero glyph or slot");

    // no read is started in the cycle a new transaction is taken
    a_intake_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !$past(mem_ctl.rd_en))
        else $error("scan read issued while taking a transaction");

endmodule : char_to_glyph_segment_map

`default_nettype wire
